// ===== design/cpsp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpsp_pkg
// Shared types, constants and arithmetic helpers for the cascaded
// position/speed PID controller.
// ----------------------------------------------------------------------------
package cpsp_pkg;

    localparam int DATA_W      = 16;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int PROD_W      = DATA_W + DIFF_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int FRAC_W      = 8;
    localparam int WIDE_W      = ACC_W - FRAC_W;
    localparam int DRIVE_W     = 10;
    localparam int CFG_ADDR_W  = 3;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 32;
    localparam int DRIVE_LIMIT_DEF = 340;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_POS_KP = 3'd0,
        REG_POS_KI = 3'd1,
        REG_POS_KD = 3'd2,
        REG_SPD_KP = 3'd3,
        REG_SPD_KD = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        MUL_POS_KP = 3'd0,
        MUL_POS_KD = 3'd1,
        MUL_POS_KI = 3'd2,
        MUL_SPD_KP = 3'd3,
        MUL_SPD_KD = 3'd4
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef struct packed {
        logic     load_in;
        logic     pos_err;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     pos_commit;
        logic     spd_err;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        if (v > WIDE_W'(32767)) begin
            return 16'sh7fff;
        end else if (v < -WIDE_W'(32768)) begin
            return 16'sh8000;
        end
        return v[DATA_W-1:0];
    endfunction

    // divide by 256, rounding toward zero
    function automatic logic signed [WIDE_W-1:0] trunc_q8(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + (v[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
        return t[ACC_W-1:FRAC_W];
    endfunction

endpackage

// ===== design/cascaded_position_speed_pid.sv =====
// Requests are taken one at a time: a new request is accepted only in idle, after
// the previous one has run its position steps (with run_outer set) and speed steps,
//   set by the sequence of multiplies through the one shared 16x17 multiplier.
// A finished result waits in the output register while the next request runs.
// Reset (aresetn low, synchronous) clears gains, loop state and setpoint to 0.
// ----------------------------------------------------------------------------
// cascaded_position_speed_pid
// One-axis cascade: position PID producing a speed setpoint, followed by a
// speed PD producing a clamped drive command.
// ----------------------------------------------------------------------------
module cascaded_position_speed_pid #(
    parameter int DRIVE_LIMIT = cpsp_pkg::DRIVE_LIMIT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cpsp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cpsp_pkg::DATA_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // target_position, measured_position, measured_speed
    input  logic [cpsp_pkg::S_TDATA_W-1:0]      s_tdata,
    // run_outer
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // drive, speed_target, zero pad
    output logic [cpsp_pkg::M_TDATA_W-1:0]      m_tdata,
    // drive_clamped
    output logic                                m_tuser
);

    cpsp_pkg::cmd_t cmd;
    cpsp_pkg::sts_t sts;

    cpsp_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_run_outer (s_tuser),
        .in_ready     (s_tready),
        .sts          (sts),
        .cmd          (cmd)
    );

    cpsp_dp #(
        .DRIVE_LIMIT (DRIVE_LIMIT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_data      (s_tdata),
        .in_run_outer (s_tuser),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (m_tdata),
        .out_clamped  (m_tuser)
    );

endmodule

// ===== design/cpsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpsp_ctrl
// Sequencer for the cascade: position PID (optional) then speed PD, issuing
// its shared-multiplier operations to the datapath in sequence.
// ----------------------------------------------------------------------------
module cpsp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_run_outer,
    output logic              in_ready,
    input  cpsp_pkg::sts_t    sts,
    output cpsp_pkg::cmd_t    cmd
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_P_ERR = 12'b0000_0000_0010,
        ST_P_M0  = 12'b0000_0000_0100,
        ST_P_M1  = 12'b0000_0000_1000,
        ST_P_M2  = 12'b0000_0001_0000,
        ST_P_A   = 12'b0000_0010_0000,
        ST_P_CMT = 12'b0000_0100_0000,
        ST_S_ERR = 12'b0000_1000_0000,
        ST_S_M0  = 12'b0001_0000_0000,
        ST_S_M1  = 12'b0010_0000_0000,
        ST_S_A   = 12'b0100_0000_0000,
        ST_S_CMT = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = cpsp_pkg::MUL_POS_KP;
        cmd.acc_op  = cpsp_pkg::ACC_HOLD;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = in_run_outer ? ST_P_ERR : ST_S_ERR;
                end
            end
            ST_P_ERR: begin
                cmd.pos_err = 1'b1;
                state_next  = ST_P_M0;
            end
            ST_P_M0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cpsp_pkg::MUL_POS_KP;
                state_next  = ST_P_M1;
            end
            ST_P_M1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cpsp_pkg::MUL_POS_KD;
                cmd.acc_op  = cpsp_pkg::ACC_LOAD;
                state_next  = ST_P_M2;
            end
            ST_P_M2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cpsp_pkg::MUL_POS_KI;
                cmd.acc_op  = cpsp_pkg::ACC_ADD;
                state_next  = ST_P_A;
            end
            ST_P_A: begin
                cmd.acc_op = cpsp_pkg::ACC_ADD;
                state_next = ST_P_CMT;
            end
            ST_P_CMT: begin
                cmd.pos_commit = 1'b1;
                state_next     = ST_S_ERR;
            end
            ST_S_ERR: begin
                cmd.spd_err = 1'b1;
                state_next  = ST_S_M0;
            end
            ST_S_M0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cpsp_pkg::MUL_SPD_KP;
                state_next  = ST_S_M1;
            end
            ST_S_M1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cpsp_pkg::MUL_SPD_KD;
                cmd.acc_op  = cpsp_pkg::ACC_LOAD;
                state_next  = ST_S_A;
            end
            ST_S_A: begin
                cmd.acc_op = cpsp_pkg::ACC_ADD;
                state_next = ST_S_CMT;
            end
            ST_S_CMT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_out_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output register occupied");

    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request accepted while busy");
`endif

endmodule

// ===== design/cpsp_dp.sv =====
// ----------------------------------------------------------------------------
// cpsp_dp
// Datapath: gain registers, loop state, shared 16x17 multiplier with
// accumulator, saturation/clamp logic and the result register.
// ----------------------------------------------------------------------------
module cpsp_dp #(
    parameter int DRIVE_LIMIT = cpsp_pkg::DRIVE_LIMIT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cpsp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cpsp_pkg::DATA_W-1:0]         cfg_wdata,
    input  logic [cpsp_pkg::S_TDATA_W-1:0]      in_data,
    input  logic                                in_run_outer,
    input  cpsp_pkg::cmd_t                      cmd,
    output cpsp_pkg::sts_t                      sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cpsp_pkg::M_TDATA_W-1:0]      out_data,
    output logic                                out_clamped
);

    localparam int DW = cpsp_pkg::DATA_W;
    localparam int WW = cpsp_pkg::WIDE_W;
    localparam logic signed [WW-1:0] LIM     = WW'(DRIVE_LIMIT);
    localparam logic signed [WW-1:0] NEG_LIM = -WW'(DRIVE_LIMIT);

    logic signed [DW-1:0] pos_kp_reg, pos_ki_reg, pos_kd_reg, spd_kp_reg, spd_kd_reg;
    logic signed [DW-1:0] target_reg, meas_pos_reg, meas_spd_reg;
    logic                 run_outer_reg;
    logic signed [DW-1:0] pos_prev_reg, pos_sum_reg, spd_prev_reg, setpoint_reg;
    logic signed [DW-1:0] err_reg, err_next;
    logic signed [cpsp_pkg::DIFF_W-1:0] diff_reg, diff_next;
    logic signed [cpsp_pkg::PROD_W-1:0] prod_reg;
    logic signed [cpsp_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DW-1:0] mul_a;
    logic signed [cpsp_pkg::DIFF_W-1:0] mul_b;
    logic signed [WW-1:0] q_wide;
    logic signed [cpsp_pkg::DRIVE_W-1:0] drive_next;
    logic                 clamp_next;
    logic                 out_valid_reg;
    logic signed [cpsp_pkg::DRIVE_W-1:0] drive_reg;
    logic signed [DW-1:0] spd_tgt_reg;
    logic                 clamped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_kp_reg <= '0;
            pos_ki_reg <= '0;
            pos_kd_reg <= '0;
            spd_kp_reg <= '0;
            spd_kd_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                cpsp_pkg::REG_POS_KP: pos_kp_reg <= cfg_wdata;
                cpsp_pkg::REG_POS_KI: pos_ki_reg <= cfg_wdata;
                cpsp_pkg::REG_POS_KD: pos_kd_reg <= cfg_wdata;
                cpsp_pkg::REG_SPD_KP: spd_kp_reg <= cfg_wdata;
                cpsp_pkg::REG_SPD_KD: spd_kd_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            target_reg    <= in_data[DW-1:0];
            meas_pos_reg  <= in_data[2*DW-1:DW];
            meas_spd_reg  <= in_data[3*DW-1:2*DW];
            run_outer_reg <= in_run_outer;
        end
    end

    always_comb begin
        err_next  = err_reg;
        diff_next = diff_reg;
        if (cmd.pos_err) begin
            err_next  = cpsp_pkg::sat16(WW'(target_reg) - WW'(meas_pos_reg));
            diff_next = cpsp_pkg::DIFF_W'(err_next) - cpsp_pkg::DIFF_W'(pos_prev_reg);
        end else if (cmd.spd_err) begin
            err_next  = cpsp_pkg::sat16(WW'(setpoint_reg) - WW'(meas_spd_reg));
            diff_next = cpsp_pkg::DIFF_W'(err_next) - cpsp_pkg::DIFF_W'(spd_prev_reg);
        end
    end

    always_comb begin
        case (cmd.mul_sel)
            cpsp_pkg::MUL_POS_KP: begin
                mul_a = pos_kp_reg;
                mul_b = cpsp_pkg::DIFF_W'(err_reg);
            end
            cpsp_pkg::MUL_POS_KD: begin
                mul_a = pos_kd_reg;
                mul_b = diff_reg;
            end
            cpsp_pkg::MUL_POS_KI: begin
                mul_a = pos_ki_reg;
                mul_b = cpsp_pkg::DIFF_W'(pos_sum_reg);
            end
            cpsp_pkg::MUL_SPD_KP: begin
                mul_a = spd_kp_reg;
                mul_b = cpsp_pkg::DIFF_W'(err_reg);
            end
            cpsp_pkg::MUL_SPD_KD: begin
                mul_a = spd_kd_reg;
                mul_b = diff_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (cmd.acc_op)
            cpsp_pkg::ACC_LOAD: acc_next = cpsp_pkg::ACC_W'(prod_reg);
            cpsp_pkg::ACC_ADD:  acc_next = acc_reg + cpsp_pkg::ACC_W'(prod_reg);
            default:            acc_next = acc_reg;
        endcase
    end

    assign q_wide = cpsp_pkg::trunc_q8(acc_reg);

    always_comb begin
        drive_next = q_wide[cpsp_pkg::DRIVE_W-1:0];
        clamp_next = 1'b0;
        if (q_wide >= LIM) begin
            drive_next = LIM[cpsp_pkg::DRIVE_W-1:0];
            clamp_next = 1'b1;
        end else if (q_wide <= NEG_LIM) begin
            drive_next = NEG_LIM[cpsp_pkg::DRIVE_W-1:0];
            clamp_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg  <= err_next;
        diff_reg <= diff_next;
        acc_reg  <= acc_next;
        if (cmd.mul_en) begin
            prod_reg <= cpsp_pkg::PROD_W'(mul_a) * cpsp_pkg::PROD_W'(mul_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_prev_reg <= '0;
            pos_sum_reg  <= '0;
            spd_prev_reg <= '0;
            setpoint_reg <= '0;
        end else begin
            if (cmd.pos_commit) begin
                setpoint_reg <= cpsp_pkg::sat16(q_wide);
                pos_sum_reg  <= cpsp_pkg::sat16(WW'(pos_sum_reg) + WW'(err_reg));
                pos_prev_reg <= err_reg;
            end
            if (cmd.out_load) begin
                spd_prev_reg <= err_reg;
            end
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            drive_reg   <= drive_next;
            spd_tgt_reg <= setpoint_reg;
            clamped_reg <= clamp_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = {{(cpsp_pkg::M_TDATA_W - cpsp_pkg::DRIVE_W - DW){1'b0}},
                          spd_tgt_reg, drive_reg};
    assign out_clamped = clamped_reg;

`ifndef SYNTH
    a_pos_commit_needs_outer: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pos_commit |-> run_outer_reg)
        else $error("position state updated for a request without run_outer");

    a_clamp_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && clamped_reg) |->
            (drive_reg == LIM[cpsp_pkg::DRIVE_W-1:0] ||
             drive_reg == NEG_LIM[cpsp_pkg::DRIVE_W-1:0]))
        else $error("clamp flag set without drive at the limit");
`endif

endmodule
